// File: hw/rtl/touch_gesture_tap_drag_pinch_defines.svh
// ----------------------------------------------------------------------------
// Touch gesture assertion macros
// Concurrent check helpers on clk with asynchronous active-low reset arst_n.
// ----------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_TAP_DRAG_PINCH_DEFINES_SVH
`define TOUCH_GESTURE_TAP_DRAG_PINCH_DEFINES_SVH

`ifndef SYNTHESIS
`define TG_ASSERT_NOW(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error(msg);
`define TG_ASSERT_NEXT(lbl, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error(msg);
`else
`define TG_ASSERT_NOW(lbl, ant, con, msg)
`define TG_ASSERT_NEXT(lbl, ant, con, msg)
`endif

`endif

// File: hw/rtl/tg_pkg.sv
// ----------------------------------------------------------------------------
// Touch gesture package
// Widths, codes, CORDIC angle table and controller/datapath bundles.
// ----------------------------------------------------------------------------
package tg_pkg;

	localparam int COORD_BITS      = 12;
	localparam int SCALE_FRAC_BITS = 8;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int SQ_W    = 2 * COORD_BITS + 1;
	localparam int DIV_W   = SQ_W + 2 * SCALE_FRAC_BITS;
	localparam int SQV_W   = DIV_W + (DIV_W % 2);
	localparam int ROOT_W  = SQV_W / 2;
	localparam int SCALE_W = 16;
	localparam int ANG_W   = 16;
	localparam int RX_W    = ((ROOT_W > SCALE_W) ? ROOT_W : SCALE_W) + 1;
	localparam int CW      = COORD_BITS + 20;
	localparam int ZW      = 20;
	localparam int CORD_STEPS = 16;
	localparam int STEP_W  = 6;

	localparam int IN_BITS     = 2 + 4 * COORD_BITS;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 2 * DIFF_W + SCALE_W + ANG_W + 2 * COORD_BITS;
	localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

	localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_MOVE  = 2'd1;
	localparam logic [1:0] FUNC_END   = 2'd2;

	localparam logic [1:0] KIND_DRAG  = 2'd0;
	localparam logic [1:0] KIND_PINCH = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_TAP   = 2'd3;

	localparam logic [2:0] OSEL_ZERO  = 3'd0;
	localparam logic [2:0] OSEL_DRAG  = 3'd1;
	localparam logic [2:0] OSEL_PINCH = 3'd2;
	localparam logic [2:0] OSEL_CLEAR = 3'd3;
	localparam logic [2:0] OSEL_TAP   = 3'd4;

	typedef struct packed {
		logic              cap_in;
		logic              load_start;
		logic              load_start2;
		logic              mul_en;
		logic              div_init;
		logic              div_en;
		logic              sqrt_init;
		logic              sqrt_en;
		logic              cord_init;
		logic              cord_en;
		logic              cord_done;
		logic              cord_sel;
		logic              out_load;
		logic [2:0]        out_sel;
		logic              out_last;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] cnt;
		logic       s2_zero;
		logic       out_free;
	} stat_t;

	// atan(2^-i) in Q.16, rounded
	function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			4'd0:    r = 20'sd51472;
			4'd1:    r = 20'sd30386;
			4'd2:    r = 20'sd16055;
			4'd3:    r = 20'sd8150;
			4'd4:    r = 20'sd4091;
			4'd5:    r = 20'sd2047;
			4'd6:    r = 20'sd1024;
			4'd7:    r = 20'sd512;
			4'd8:    r = 20'sd256;
			4'd9:    r = 20'sd128;
			4'd10:   r = 20'sd64;
			4'd11:   r = 20'sd32;
			4'd12:   r = 20'sd16;
			4'd13:   r = 20'sd8;
			4'd14:   r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/touch_gesture_tap_drag_pinch.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer: tap, drag and two-finger pinch
// Input channel s_axis carries one touch event per item: tuser is the event
// kind, tdata the point count and up to two points. Output channel m_axis
// carries gesture results: tuser is the result kind, tlast marks the final
// result of an event.
// Sequencing: the controller takes one item at a time. Start and ignored
// events return to idle after decode; one-point moves and ends load one
// result. A two-point move with a known base emits a zero drag, then runs 4
// squarer passes, a 41-step shift-subtract divider, a 21-step square root
// and two CORDIC passes before the pinch result; the divider dominates.
// The result register decouples the channels: a new item is taken while a
// result waits, and the sequencer holds before loading a result until the
// receiver frees the register, so a stalled receiver stalls the block.
// Reset clears drag/pinch mode, the start points and the output valid.
// ----------------------------------------------------------------------------
`include "touch_gesture_tap_drag_pinch_defines.svh"

module touch_gesture_tap_drag_pinch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// point_count[1:0], first_x, first_y, second_x, second_y, zero fill
	input  logic [tg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// func[1:0]
	input  logic [1:0]                    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// drag_dx, drag_dy, pinch_scale, pinch_angle, tap_x, tap_y, zero fill
	output logic [tg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// kind[1:0]
	output logic [1:0]                    m_axis_tuser,
	output logic                          m_axis_tlast
);
	import tg_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: event decode, mode flags, step counting
	tg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic and result register
	tg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	// never overwrite a result that has not been taken
	`TG_ASSERT_NOW(a_no_overwrite, cmd.out_load, stat.out_free, "result overwritten")
	// one item in work at a time
	`TG_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item overlap")
	// the pinch result cannot follow its zero drag on the next cycle
	`TG_ASSERT_NEXT(a_pinch_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid, "pinch too early")

endmodule

// File: hw/rtl/tg_ctrl.sv
// ----------------------------------------------------------------------------
// Touch gesture controller
// Decodes each event, tracks drag/pinch mode and sequences the pinch math.
// ----------------------------------------------------------------------------
module tg_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  tg_pkg::stat_t stat,
	output tg_pkg::cmd_t  cmd
);
	import tg_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECIDE = 4'd1;
	localparam logic [3:0] ST_EMIT   = 4'd2;
	localparam logic [3:0] ST_MUL    = 4'd3;
	localparam logic [3:0] ST_DIV    = 4'd4;
	localparam logic [3:0] ST_SQRT   = 4'd5;
	localparam logic [3:0] ST_CORA   = 4'd6;
	localparam logic [3:0] ST_CORB   = 4'd7;
	localparam logic [3:0] ST_FIN    = 4'd8;

	localparam logic [STEP_W-1:0] STEP_MUL_END  = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_DIV_END  = STEP_W'(DIV_W);
	localparam logic [STEP_W-1:0] STEP_SQRT_END = STEP_W'(ROOT_W);
	localparam logic [STEP_W-1:0] STEP_CORD_END = STEP_W'(CORD_STEPS + 1);

	logic [3:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              dragging_q, dragging_d;
	logic              pinching_q, pinching_d;
	logic [2:0]        sel_q, sel_d;
	logic              last_q, last_d;
	logic              more_q, more_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.step   = step_q;
		state_d    = state_q;
		step_d     = step_q;
		dragging_d = dragging_q;
		pinching_d = pinching_q;
		sel_d      = sel_q;
		last_d     = last_q;
		more_d     = more_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_IDLE;
				case (stat.func)
					FUNC_START: begin
						cmd.load_start = 1'b1;
						dragging_d     = 1'b0;
						pinching_d     = 1'b0;
					end
					FUNC_MOVE: begin
						if (stat.cnt >= 2'd2) begin
							pinching_d = 1'b1;
							dragging_d = 1'b0;
							sel_d      = OSEL_ZERO;
							state_d    = ST_EMIT;
							if (stat.s2_zero) begin
								// no second start point yet: take this one as base
								cmd.load_start2 = 1'b1;
								last_d          = 1'b1;
								more_d          = 1'b0;
							end else begin
								last_d = 1'b0;
								more_d = 1'b1;
							end
						end else if (stat.cnt == 2'd1 && !pinching_q) begin
							dragging_d = 1'b1;
							sel_d      = OSEL_DRAG;
							last_d     = 1'b1;
							more_d     = 1'b0;
							state_d    = ST_EMIT;
						end
					end
					FUNC_END: begin
						if (stat.cnt == 2'd0) begin
							last_d  = 1'b1;
							more_d  = 1'b0;
							state_d = ST_EMIT;
							if (dragging_q) begin
								dragging_d = 1'b0;
								sel_d      = OSEL_ZERO;
							end else if (pinching_q) begin
								pinching_d = 1'b0;
								sel_d      = OSEL_CLEAR;
							end else begin
								sel_d = OSEL_TAP;
							end
						end
					end
					default: ;
				endcase
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = sel_q;
					cmd.out_last = last_q;
					step_d       = '0;
					state_d      = more_q ? ST_MUL : ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (step_q == STEP_MUL_END) begin
					step_d  = '0;
					state_d = ST_DIV;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_init = (step_q == '0);
				cmd.div_en   = (step_q != '0);
				if (step_q == STEP_DIV_END) begin
					step_d  = '0;
					state_d = ST_SQRT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_init = (step_q == '0);
				cmd.sqrt_en   = (step_q != '0);
				if (step_q == STEP_SQRT_END) begin
					step_d  = '0;
					state_d = ST_CORA;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_CORA, ST_CORB: begin
				cmd.cord_sel = (state_q == ST_CORB);
				if (step_q == '0) begin
					cmd.cord_init = 1'b1;
					step_d        = step_q + 1'b1;
				end else if (step_q == STEP_CORD_END) begin
					cmd.cord_done = 1'b1;
					step_d        = '0;
					state_d       = (state_q == ST_CORA) ? ST_CORB : ST_FIN;
				end else begin
					cmd.cord_en = 1'b1;
					step_d      = step_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_PINCH;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			dragging_q <= 1'b0;
			pinching_q <= 1'b0;
			sel_q      <= OSEL_ZERO;
			last_q     <= 1'b0;
			more_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			step_q     <= step_d;
			dragging_q <= dragging_d;
			pinching_q <= pinching_d;
			sel_q      <= sel_d;
			last_q     <= last_d;
			more_q     <= more_d;
		end
	end

endmodule

// File: hw/rtl/tg_dp.sv
// ----------------------------------------------------------------------------
// Touch gesture datapath
// Start points, squarer, shift-subtract divider, square root, CORDIC, output.
// ----------------------------------------------------------------------------
module tg_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tg_pkg::cmd_t                  cmd,
	output tg_pkg::stat_t                 stat,
	input  logic [tg_pkg::IN_DATA_W-1:0]  in_data,
	input  logic [1:0]                    in_user,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tg_pkg::OUT_DATA_W-1:0] out_data,
	output logic [1:0]                    out_user,
	output logic                          out_last
);
	import tg_pkg::*;

	logic [1:0]            func_q, cnt_q;
	logic [COORD_BITS-1:0] fx_q, fy_q, sx_q, sy_q;
	logic [COORD_BITS-1:0] start_x_q, start_y_q, start2_x_q, start2_y_q;

	logic [SQ_W-1:0]       d1_q, d0_q, rem_q;
	logic [DIV_W-1:0]      quo_q;
	logic [SQV_W-1:0]      sqv_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_W+1:0]     srem_q;
	logic signed [CW-1:0]  x_q, y_q;
	logic signed [ZW-1:0]  z_q;
	logic                  zvec_q;
	logic signed [ZW:0]    ang_q;

	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [DIFF_W-1:0]     dx_q, dy_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [ANG_W-1:0]      angle_q;
	logic [COORD_BITS-1:0] tx_q, ty_q;
	logic                  last_q;

	// capture the item
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			func_q <= in_user;
			cnt_q  <= in_data[1:0];
			fx_q   <= in_data[2 +: COORD_BITS];
			fy_q   <= in_data[2 + COORD_BITS +: COORD_BITS];
			sx_q   <= in_data[2 + 2 * COORD_BITS +: COORD_BITS];
			sy_q   <= in_data[2 + 3 * COORD_BITS +: COORD_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q  <= '0;
			start_y_q  <= '0;
			start2_x_q <= '0;
			start2_y_q <= '0;
		end else if (cmd.load_start) begin
			start_x_q  <= fx_q;
			start_y_q  <= fy_q;
			start2_x_q <= (cnt_q >= 2'd2) ? sx_q : '0;
			start2_y_q <= (cnt_q >= 2'd2) ? sy_q : '0;
		end else if (cmd.load_start2) begin
			start2_x_q <= sx_q;
			start2_y_q <= sy_q;
		end
	end

	// finger vectors
	logic signed [DIFF_W-1:0] cdx, cdy, bdx, bdy, ddx, ddy;
	assign cdx = $signed({1'b0, sx_q}) - $signed({1'b0, fx_q});
	assign cdy = $signed({1'b0, sy_q}) - $signed({1'b0, fy_q});
	assign bdx = $signed({1'b0, start2_x_q}) - $signed({1'b0, start_x_q});
	assign bdy = $signed({1'b0, start2_y_q}) - $signed({1'b0, start_y_q});
	assign ddx = $signed({1'b0, fx_q}) - $signed({1'b0, start_x_q});
	assign ddy = $signed({1'b0, fy_q}) - $signed({1'b0, start_y_q});

	// one squarer, four passes
	logic signed [DIFF_W-1:0]   mop;
	logic signed [2*DIFF_W-1:0] msq;
	logic [SQ_W-1:0]            sqv;
	always_comb begin
		case (cmd.step[1:0])
			2'd0:    mop = cdx;
			2'd1:    mop = cdy;
			2'd2:    mop = bdx;
			default: mop = bdy;
		endcase
	end
	assign msq = mop * mop;
	assign sqv = msq[SQ_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.step[1:0])
				2'd0:    d1_q <= sqv;
				2'd1:    d1_q <= d1_q + sqv;
				2'd2:    d0_q <= sqv;
				default: d0_q <= d0_q + sqv;
			endcase
		end
	end

	// restoring divider, one quotient bit a step
	logic [SQ_W+1:0] dtrial;
	assign dtrial = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, d0_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= {d1_q, {(2 * SCALE_FRAC_BITS){1'b0}}};
		end else if (cmd.div_en) begin
			if (!dtrial[SQ_W+1]) begin
				rem_q <= dtrial[SQ_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SQ_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// square root, one root bit a step
	logic [ROOT_W+3:0] srs, strial, sdiff;
	assign srs    = {srem_q, sqv_q[SQV_W-1 -: 2]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sdiff  = srs - strial;

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sqv_q  <= SQV_W'(quo_q);
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_en) begin
			sqv_q <= {sqv_q[SQV_W-3:0], 2'b00};
			if (srs >= strial) begin
				srem_q <= sdiff[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				srem_q <= srs[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	logic [RX_W-1:0]    rootx;
	logic [SCALE_W-1:0] scale;
	assign rootx = RX_W'(root_q);
	assign scale = ((d0_q == '0) || (rootx > RX_W'({SCALE_W{1'b1}}))) ?
		{SCALE_W{1'b1}} : rootx[SCALE_W-1:0];

	// CORDIC vectoring
	logic signed [DIFF_W-1:0] vx, vy, nvx, nvy;
	logic signed [CW-1:0]     ex, ey, xs, ys;
	logic [STEP_W-1:0]        cidx;
	logic [3:0]               ci;
	logic signed [ZW-1:0]     zres;
	assign vx   = cmd.cord_sel ? bdx : cdx;
	assign vy   = cmd.cord_sel ? bdy : cdy;
	assign nvx  = vx[DIFF_W-1] ? -vx : vx;
	assign nvy  = vx[DIFF_W-1] ? -vy : vy;
	assign ex   = CW'(nvx) <<< 16;
	assign ey   = CW'(nvy) <<< 16;
	assign cidx = cmd.step - 1'b1;
	assign ci   = cidx[3:0];
	assign xs   = x_q >>> ci;
	assign ys   = y_q >>> ci;
	assign zres = zvec_q ? '0 : z_q;

	always_ff @(posedge clk) begin
		if (cmd.cord_init) begin
			x_q    <= ex;
			y_q    <= ey;
			zvec_q <= (vx == '0) && (vy == '0);
			if (vx[DIFF_W-1]) begin
				z_q <= vy[DIFF_W-1] ? -PI_Q16 : PI_Q16;
			end else begin
				z_q <= '0;
			end
		end else if (cmd.cord_en) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q16(ci);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q16(ci);
			end
		end
		if (cmd.cord_done) begin
			ang_q <= cmd.cord_sel ? (ang_q - (ZW + 1)'(zres)) : (ZW + 1)'(zres);
		end
	end

	logic signed [ZW:0] ang_rnd;
	assign ang_rnd = (ang_q + (ZW + 1)'(8)) >>> 4;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q  <= KIND_DRAG;
			dx_q    <= '0;
			dy_q    <= '0;
			scale_q <= '0;
			angle_q <= '0;
			tx_q    <= '0;
			ty_q    <= '0;
			last_q  <= cmd.out_last;
			case (cmd.out_sel)
				OSEL_DRAG: begin
					dx_q <= ddx;
					dy_q <= ddy;
				end
				OSEL_PINCH: begin
					kind_q  <= KIND_PINCH;
					scale_q <= scale;
					angle_q <= ang_rnd[ANG_W-1:0];
				end
				OSEL_CLEAR: kind_q <= KIND_CLEAR;
				OSEL_TAP: begin
					kind_q <= KIND_TAP;
					tx_q   <= start_x_q;
					ty_q   <= start_y_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_user  = kind_q;
	assign out_last  = last_q;
	assign out_data  = OUT_DATA_W'({ty_q, tx_q, angle_q, scale_q, dy_q, dx_q});

	assign stat.func     = func_q;
	assign stat.cnt      = cnt_q;
	assign stat.s2_zero  = (start2_x_q == '0) && (start2_y_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

endmodule
